[sv/ir_pulse_capture_matcher_assert.svh]
// Assertion macros shared by the IR pulse capture matcher modules.
`ifndef IR_PULSE_CAPTURE_MATCHER_ASSERT_SVH
`define IR_PULSE_CAPTURE_MATCHER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define IPCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low
`define IPCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ipcm_pkg.sv]
// Shared types and constants of the IR pulse capture matcher.
package ipcm_pkg;

    // Default store depth in pairs
    localparam int MAX_PAIRS_DEF = 128;

    // Queue between front and back, a power of two
    localparam int FIFO_DEPTH = 4;

    // Item modes on the input stream
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_REF   = 2'd2;

    // What the back end does with a queued entry
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CMP   = 2'd2;
    localparam logic [1:0] KIND_LAST  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_RESOLUTION = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  RESOLUTION_RST = 8'd20;
    localparam logic [6:0]  TOLERANCE_RST  = 7'd25;
    localparam logic [15:0] TIMEOUT_RST    = 16'd65000;

    // floor(x/10) for x < 2^24: (x * RECIP10) >> 28
    localparam logic [24:0] RECIP10 = 25'd26843546;
    // floor(x/100) for x < 2^23: (x * RECIP100) >> 30
    localparam logic [23:0] RECIP100 = 24'd10737419;

    // One queued item from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic        done;
        logic [7:0]  count;
        logic [15:0] ref_on;
        logic [15:0] ref_off;
        logic [15:0] low_cnt;
        logic [15:0] high_cnt;
    } ipcm_entry_t;

endpackage

[sv/ipcm_front.sv]
// Front end: capture state machine, pair stores and classification of items.
`include "ir_pulse_capture_matcher_assert.svh"

module ipcm_front #(
    parameter int MAX_PAIRS = ipcm_pkg::MAX_PAIRS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_mode,
    input  logic                  in_level,
    input  logic [15:0]           in_ref_on,
    input  logic [15:0]           in_ref_off,
    input  logic                  in_ref_last,
    input  logic [15:0]           timeout_ticks,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ipcm_pkg::ipcm_entry_t out_entry
);
    import ipcm_pkg::*;

    localparam int AW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAIRS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] pairs_reg, pairs_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    logic [15:0]   run_reg, run_next;
    logic [15:0]   run_inc;
    logic [CW:0]   idx_p1;
    logic          wr_high, wr_low, rd_en;
    logic [1:0]    kind;
    logic          accept;
    logic [CW+7:0] pairs_wide;

    logic [15:0] high_mem [MAX_PAIRS];
    logic [15:0] low_mem  [MAX_PAIRS];
    logic [15:0] rd_low_reg, rd_high_reg;

    logic        ov_reg;
    logic [1:0]  kind_reg;
    logic        done_reg;
    logic [7:0]  count_reg;
    logic [15:0] ron_reg, roff_reg;

    assign accept   = in_valid && in_ready;
    assign in_ready = !ov_reg || out_ready;
    assign run_inc  = (run_reg == 16'hFFFF) ? run_reg : run_reg + 16'd1;
    assign idx_p1   = {1'b0, ridx_reg} + {{CW{1'b0}}, 1'b1};

    // Next capture state for the offered item
    always_comb
    begin
        phase_next = phase_reg;
        pairs_next = pairs_reg;
        run_next   = run_reg;
        ridx_next  = ridx_reg;
        wr_high    = 1'b0;
        wr_low     = 1'b0;
        rd_en      = 1'b0;
        kind       = KIND_NONE;
        case (in_mode)
            MODE_START:
            begin
                phase_next = PH_HIGH;
                pairs_next = '0;
                run_next   = '0;
                ridx_next  = '0;
                kind       = KIND_START;
            end
            MODE_TICK:
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        if (in_level)
                        begin
                            run_next = run_inc;
                        end
                        else
                        begin
                            wr_high    = 1'b1;
                            phase_next = PH_LOW;
                            run_next   = 16'd1;
                        end
                        if (run_next >= timeout_ticks && pairs_reg != '0)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_LOW:
                    begin
                        if (!in_level)
                        begin
                            run_next = run_inc;
                            if (run_next >= timeout_ticks && pairs_reg != '0)
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        else
                        begin
                            wr_low     = 1'b1;
                            pairs_next = pairs_reg + {{(CW-1){1'b0}}, 1'b1};
                            if (pairs_next >= MAX_CNT)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_HIGH;
                                run_next   = 16'd1;
                                // new run starts at one tick, pairs now nonzero
                                if (16'd1 >= timeout_ticks)
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_REF:
            begin
                if (in_ref_last)
                begin
                    ridx_next = '0;
                    kind      = KIND_LAST;
                end
                else
                begin
                    // compare only when both low[i] and high[i+1] were captured
                    rd_en = ({1'b0, pairs_reg} > idx_p1);
                    kind  = rd_en ? KIND_CMP : KIND_NONE;
                    if (ridx_reg < MAX_CNT)
                    begin
                        ridx_next = ridx_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end

    assign pairs_wide = {8'd0, pairs_next};

    // Capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pairs_reg <= '0;
            run_reg   <= '0;
            ridx_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pairs_reg <= pairs_next;
            run_reg   <= run_next;
            ridx_reg  <= ridx_next;
        end
    end

    // Pair stores: at most one write per tick, registered reads for a compare
    always_ff @(posedge clk)
    begin
        if (accept && wr_high)
        begin
            high_mem[pairs_reg[AW-1:0]] <= run_reg;
        end
        if (accept && wr_low)
        begin
            low_mem[pairs_reg[AW-1:0]] <= run_reg;
        end
        if (accept && rd_en)
        begin
            rd_low_reg  <= low_mem[ridx_reg[AW-1:0]];
            rd_high_reg <= high_mem[idx_p1[AW-1:0]];
        end
    end

    // Output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ov_reg <= in_valid;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            done_reg  <= (phase_next == PH_DONE);
            count_reg <= pairs_wide[7:0];
            ron_reg   <= in_ref_on;
            roff_reg  <= in_ref_off;
        end
    end

    assign out_valid         = ov_reg;
    assign out_entry.kind    = kind_reg;
    assign out_entry.done    = done_reg;
    assign out_entry.count   = count_reg;
    assign out_entry.ref_on  = ron_reg;
    assign out_entry.ref_off = roff_reg;
    assign out_entry.low_cnt = rd_low_reg;
    assign out_entry.high_cnt = rd_high_reg;

    // A live capture never holds a full store
    `IPCM_ASSERT_IMP(a_capture_not_full, (phase_reg == PH_HIGH || phase_reg == PH_LOW), (pairs_reg < MAX_CNT), "capture active with full store")
    // Reference index saturates at the store depth
    `IPCM_ASSERT_IMP(a_ridx_bound, 1'b1, (ridx_reg <= MAX_CNT), "reference index past store depth")

endmodule

[sv/ipcm_fifo.sv]
// Short queue of classified entries between front and back end.
`include "ir_pulse_capture_matcher_assert.svh"

module ipcm_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ipcm_pkg::ipcm_entry_t in_entry,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ipcm_pkg::ipcm_entry_t out_entry
);
    import ipcm_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW:0] FULL_CNT = (PW+1)'(FIFO_DEPTH);

    ipcm_entry_t   slot_reg [FIFO_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_entry = slot_reg[rptr_reg];

    // Pointers and fill count; depth is a power of two so pointers wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + {{(PW-1){1'b0}}, 1'b1};
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + {{(PW-1){1'b0}}, 1'b1};
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + {{PW{1'b0}}, 1'b1};
                2'b01:   cnt_reg <= cnt_reg - {{PW{1'b0}}, 1'b1};
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= in_entry;
        end
    end

    `IPCM_ASSERT_IMP(a_fifo_bound, 1'b1, (cnt_reg <= FULL_CNT), "queue count past depth")

endmodule

[sv/ipcm_back.sv]
// Back end: scaled tolerance compares, match accumulation and result register.
`include "ir_pulse_capture_matcher_assert.svh"

module ipcm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ipcm_pkg::ipcm_entry_t in_entry,
    input  logic [7:0]            resolution_us,
    input  logic [6:0]            tolerance_pct,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_done,
    output logic [7:0]            out_count,
    output logic                  out_cmp_valid,
    output logic                  out_match
);
    import ipcm_pkg::*;

    logic en;

    // stage 1: raw products
    logic        s1_v;
    logic [1:0]  s1_kind;
    logic        s1_done;
    logic [7:0]  s1_count;
    logic [15:0] s1_ron, s1_roff;
    logic [23:0] s1_pon, s1_poff;
    logic [22:0] s1_ton, s1_toff;

    // stage 2: divided values
    logic        s2_v;
    logic [1:0]  s2_kind;
    logic        s2_done;
    logic [7:0]  s2_count;
    logic [15:0] s2_ron, s2_roff;
    logic [20:0] s2_mon, s2_moff;
    logic [16:0] s2_thon, s2_thoff;

    logic [48:0] mon_full, moff_full;
    logic [46:0] thon_full, thoff_full;
    logic [20:0] ron_w, roff_w, diff_on, diff_off;
    logic        ok_on, ok_off;

    logic        ov_reg;
    logic        done_reg, cv_reg, match_reg;
    logic [7:0]  count_reg;
    logic        am_reg;

    // whole pipeline advances while the result register can move
    assign en       = !ov_reg || out_ready;
    assign in_ready = en;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v <= 1'b0;
            s2_v <= 1'b0;
        end
        else if (en)
        begin
            s1_v <= in_valid;
            s2_v <= s1_v;
        end
    end

    // stage 1: count * resolution, reference * tolerance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind  <= in_entry.kind;
            s1_done  <= in_entry.done;
            s1_count <= in_entry.count;
            s1_ron   <= in_entry.ref_on;
            s1_roff  <= in_entry.ref_off;
            s1_pon   <= 24'(in_entry.low_cnt) * 24'(resolution_us);
            s1_poff  <= 24'(in_entry.high_cnt) * 24'(resolution_us);
            s1_ton   <= 23'(in_entry.ref_on) * 23'(tolerance_pct);
            s1_toff  <= 23'(in_entry.ref_off) * 23'(tolerance_pct);
        end
    end

    // reciprocal multiplies for the floor divisions by ten and one hundred
    assign mon_full   = 49'(s1_pon) * 49'(RECIP10);
    assign moff_full  = 49'(s1_poff) * 49'(RECIP10);
    assign thon_full  = 47'(s1_ton) * 47'(RECIP100);
    assign thoff_full = 47'(s1_toff) * 47'(RECIP100);

    // stage 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_kind  <= s1_kind;
            s2_done  <= s1_done;
            s2_count <= s1_count;
            s2_ron   <= s1_ron;
            s2_roff  <= s1_roff;
            s2_mon   <= mon_full[48:28];
            s2_moff  <= moff_full[48:28];
            s2_thon  <= thon_full[46:30];
            s2_thoff <= thoff_full[46:30];
        end
    end

    // absolute deviation against threshold
    assign ron_w    = {5'd0, s2_ron};
    assign roff_w   = {5'd0, s2_roff};
    assign diff_on  = (s2_mon >= ron_w) ? (s2_mon - ron_w) : (ron_w - s2_mon);
    assign diff_off = (s2_moff >= roff_w) ? (s2_moff - roff_w) : (roff_w - s2_moff);
    assign ok_on    = (diff_on <= {4'd0, s2_thon});
    assign ok_off   = (diff_off <= {4'd0, s2_thoff});

    // running match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            am_reg <= 1'b1;
        end
        else if (en && s2_v)
        begin
            case (s2_kind)
                KIND_START: am_reg <= 1'b1;
                KIND_LAST:  am_reg <= 1'b1;
                KIND_CMP:   am_reg <= am_reg && ok_on && ok_off;
                default:    am_reg <= am_reg;
            endcase
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= s2_v;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            done_reg  <= s2_done;
            count_reg <= s2_count;
            cv_reg    <= (s2_kind == KIND_LAST);
            match_reg <= (s2_kind == KIND_LAST) && am_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign out_done      = done_reg;
    assign out_count     = count_reg;
    assign out_cmp_valid = cv_reg;
    assign out_match     = match_reg;

    // closing a code rearms the match flag
    `IPCM_ASSERT_NXT(a_last_rearms, (en && s2_v && s2_kind == KIND_LAST), am_reg, "match flag not rearmed after last pair")
    // a failed compare always clears the match flag
    `IPCM_ASSERT_NXT(a_miss_clears, (en && s2_v && s2_kind == KIND_CMP && !(ok_on && ok_off)), !am_reg, "failed compare kept match flag")

endmodule

[sv/ir_pulse_capture_matcher.sv]
// Top level: IR pulse width capture and reference code matcher.
// Path: front output register, queue slot, back stages 1 and 2, then the result register on m_tvalid.
// Throughput: one item per cycle unless m_tready stalls it; the capture state machine in the front end
// finishes each item when it is accepted and the compare pipeline takes one per cycle while not stalled.
// Reset: control state clears, registers load 20 us / 25 pct / 65000 ticks;
// the pair stores are not cleared and need no clearing pass.
module ir_pulse_capture_matcher #(
    parameter int MAX_PAIRS = ipcm_pkg::MAX_PAIRS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [0] pin_level, [16:1] ref_on, [32:17] ref_off, rest 0
    input  logic [1:0]  s_tuser,    // [1:0] mode
    input  logic        s_tlast,    // ref_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] capture_done, [8:1] pair_count, [9] match, rest 0
    output logic        m_tuser,    // compare_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ipcm_pkg::*;

    logic [7:0]  res_reg;
    logic [6:0]  tol_reg;
    logic [15:0] tmo_reg;

    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    ipcm_entry_t fq_entry, qb_entry;

    logic        r_done, r_cv, r_match;
    logic [7:0]  r_count;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RESOLUTION_RST;
            tol_reg <= TOLERANCE_RST;
            tmo_reg <= TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RESOLUTION: res_reg <= cfg_data[7:0];
                CFG_TOLERANCE:  tol_reg <= cfg_data[6:0];
                CFG_TIMEOUT:    tmo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front end
    ipcm_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_mode       (s_tuser),
        .in_level      (s_tdata[0]),
        .in_ref_on     (s_tdata[16:1]),
        .in_ref_off    (s_tdata[32:17]),
        .in_ref_last   (s_tlast),
        .timeout_ticks (tmo_reg),
        .out_valid     (fq_valid),
        .out_ready     (fq_ready),
        .out_entry     (fq_entry)
    );

    // Decoupling queue
    ipcm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_entry (qb_entry)
    );

    // Back end
    ipcm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_entry      (qb_entry),
        .resolution_us (res_reg),
        .tolerance_pct (tol_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_done      (r_done),
        .out_count     (r_count),
        .out_cmp_valid (r_cv),
        .out_match     (r_match)
    );

    assign m_tdata = {6'd0, r_match, r_count, r_done};
    assign m_tuser = r_cv;

endmodule
